### rtl/core/totp_pkg.sv
package totp_pkg;

	localparam int KEY_BYTES_DEF = 64;
	localparam int HMAC_BLOCK = 64;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_STEP = 2'd1;
	localparam logic [1:0] ST_ZERO_MOD = 2'd2;
	localparam logic [1:0] ST_KEY_LONG = 2'd3;

	localparam logic REG_TIME_STEP = 1'b0;
	localparam logic REG_CODE_MOD  = 1'b1;

	localparam logic [7:0]  TIME_STEP_RST = 8'd30;
	localparam logic [31:0] CODE_MOD_RST  = 32'd1000000;

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5C;
	localparam logic [3:0] OFF_MASK = 4'hF;
	localparam logic [7:0] TOP_MASK = 8'h7F;

	localparam logic [159:0] SHA1_IV =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DIV1,
		FSM_KEY,
		FSM_SHA_GO,
		FSM_SHA_WAIT,
		FSM_DIV2,
		FSM_OUT
	} fsm_t;

	function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = 32'h5A827999;
		end else if (rnd < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (rnd < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

endpackage

### rtl/core/totp_if.sv
interface totp_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [31:0] unix_time;

	modport source (output valid, opcode, key_byte, key_last, unix_time, input ready);
	modport sink (input valid, opcode, key_byte, key_last, unix_time, output ready);
endinterface

interface totp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] otp_value;
	logic [1:0]  status;

	modport source (output valid, otp_value, status, input ready);
	modport sink (input valid, otp_value, status, output ready);
endinterface

### rtl/core/totp_code_generator.sv
// TOTP code generator, HMAC-SHA1 with dynamic truncation.
// in_ch carries transactions: opcode load stores key_byte in the key store
// (key_last closes the key, the next load starts a new one); opcode compute
// takes unix_time and yields one transaction on out_ch with otp_value and
// status. Loads yield nothing.
// Registers on the APB port: time_step at 0x0, code_modulus at 0x4.
// A compute runs a 32-step divide for the counter, a sweep reading the
// key store, four SHA-1 compressions of 80 rounds through one round unit,
// a 32-step divide for the modulus and a load of the result into the
// output register. With an error status the compute skips these and goes
// from the idle state straight to the output state.
// in_ch.ready is low while a compute runs. The result sits in an output
// register; a stalled receiver holds it there while loads keep going, and
// a following compute waits at its end until the register is free.
// Reset (arst_n low) empties the key, restores the register defaults and
// drops any pending result. The key store has no reset.
module totp_code_generator #(
	parameter int KEY_BYTES = totp_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	totp_in_if.sink     in_ch,
	totp_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(KEY_BYTES);
	localparam int CW = $clog2(KEY_BYTES + 1);

	logic [7:0]   key_mem [KEY_BYTES];
	logic [7:0]   rd_data_q;

	logic [7:0]   time_step_q;
	logic [31:0]  code_mod_q;
	logic [CW-1:0] key_count_q;
	logic         key_ovf_q;
	logic         restart_q;

	totp_pkg::fsm_t state_q, state_d;

	logic [31:0]  utime_q;
	logic [31:0]  counter_q;
	logic [511:0] key_blk_q;
	logic [159:0] h_q;
	logic [159:0] inner_q;
	logic [1:0]   phase_q;
	logic [6:0]   rd_idx_q;
	logic         rd_v_s1;
	logic         rd_use_s1;
	logic [1:0]   status_q;

	logic         out_valid_q;
	logic [31:0]  otp_q;
	logic [1:0]   ostat_q;

	logic         in_acc;
	logic         load_acc;
	logic         comp_acc;
	logic [CW-1:0] cnt_base;
	logic         wr_en;
	logic [1:0]   err_status;

	logic         div_start;
	logic [31:0]  div_num, div_den, div_quo, div_rem;
	logic         div_busy, div_done;

	logic         sha_start;
	logic [511:0] sha_blk;
	logic [159:0] sha_hin, sha_hout;
	logic         sha_done;

	logic [159:0] dig_sh;
	logic [31:0]  trunc;
	logic         out_load;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == totp_pkg::REG_CODE_MOD) ? code_mod_q : {24'd0, time_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= totp_pkg::TIME_STEP_RST;
			code_mod_q  <= totp_pkg::CODE_MOD_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == totp_pkg::REG_TIME_STEP) begin
				time_step_q <= pwdata[7:0];
			end else begin
				code_mod_q <= pwdata;
			end
		end
	end

	assign in_ch.ready = (state_q == totp_pkg::FSM_IDLE);
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign load_acc = in_acc && (in_ch.opcode == totp_pkg::OP_LOAD);
	assign comp_acc = in_acc && (in_ch.opcode == totp_pkg::OP_COMPUTE);
	assign cnt_base = restart_q ? '0 : key_count_q;
	assign wr_en    = load_acc && (cnt_base < CW'(KEY_BYTES));

	always_comb begin
		if (time_step_q == 8'd0) begin
			err_status = totp_pkg::ST_ZERO_STEP;
		end else if (code_mod_q == 32'd0) begin
			err_status = totp_pkg::ST_ZERO_MOD;
		end else if (key_ovf_q) begin
			err_status = totp_pkg::ST_KEY_LONG;
		end else begin
			err_status = totp_pkg::ST_OK;
		end
	end

	// key store: one write port for loads, one registered read for the sweep
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[cnt_base[AW-1:0]] <= in_ch.key_byte;
		end
		rd_data_q <= key_mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			key_ovf_q   <= 1'b0;
			restart_q   <= 1'b1;
		end else if (load_acc) begin
			restart_q <= in_ch.key_last;
			if (wr_en) begin
				key_count_q <= cnt_base + CW'(1);
				key_ovf_q   <= restart_q ? 1'b0 : key_ovf_q;
			end else begin
				key_count_q <= cnt_base;
				key_ovf_q   <= 1'b1;
			end
		end
	end

	totp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	totp_sha1 u_sha1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.blk    (sha_blk),
		.h_in   (sha_hin),
		.done   (sha_done),
		.h_out  (sha_hout)
	);

	assign dig_sh = h_q << {h_q[3:0] & totp_pkg::OFF_MASK, 3'b000};
	assign trunc  = {dig_sh[159:152] & totp_pkg::TOP_MASK, dig_sh[151:128]};

	always_comb begin
		case (phase_q)
			2'd0: begin
				sha_blk = key_blk_q ^ {64{totp_pkg::IPAD}};
				sha_hin = totp_pkg::SHA1_IV;
			end
			2'd1: begin
				sha_blk = {32'd0, counter_q, 32'h8000_0000, 384'd0, 32'h0000_0240};
				sha_hin = h_q;
			end
			2'd2: begin
				sha_blk = key_blk_q ^ {64{totp_pkg::OPAD}};
				sha_hin = totp_pkg::SHA1_IV;
			end
			default: begin
				sha_blk = {inner_q, 32'h8000_0000, 288'd0, 32'h0000_02A0};
				sha_hin = h_q;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = utime_q;
		div_den   = {24'd0, time_step_q};
		sha_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			totp_pkg::FSM_IDLE: begin
				if (comp_acc) begin
					state_d = (err_status == totp_pkg::ST_OK) ? totp_pkg::FSM_DIV1
						: totp_pkg::FSM_OUT;
				end
			end
			totp_pkg::FSM_DIV1: begin
				div_start = !div_busy && !div_done;
				if (div_done) begin
					state_d = totp_pkg::FSM_KEY;
				end
			end
			totp_pkg::FSM_KEY: begin
				if (rd_idx_q == 7'(totp_pkg::HMAC_BLOCK) && rd_v_s1) begin
					state_d = totp_pkg::FSM_SHA_GO;
				end
			end
			totp_pkg::FSM_SHA_GO: begin
				sha_start = 1'b1;
				state_d   = totp_pkg::FSM_SHA_WAIT;
			end
			totp_pkg::FSM_SHA_WAIT: begin
				if (sha_done) begin
					state_d = (phase_q == 2'd3) ? totp_pkg::FSM_DIV2 : totp_pkg::FSM_SHA_GO;
				end
			end
			totp_pkg::FSM_DIV2: begin
				div_num   = trunc;
				div_den   = code_mod_q;
				div_start = !div_busy && !div_done;
				if (div_done) begin
					state_d = totp_pkg::FSM_OUT;
				end
			end
			totp_pkg::FSM_OUT: begin
				if (!out_valid_q) begin
					out_load = 1'b1;
					state_d  = totp_pkg::FSM_IDLE;
				end
			end
			default: state_d = totp_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= totp_pkg::FSM_IDLE;
			phase_q <= '0;
			rd_idx_q <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == totp_pkg::FSM_KEY) && (rd_idx_q < 7'(totp_pkg::HMAC_BLOCK));
			if (state_q == totp_pkg::FSM_IDLE) begin
				phase_q  <= '0;
				rd_idx_q <= '0;
			end else if (state_q == totp_pkg::FSM_KEY) begin
				if (rd_idx_q < 7'(totp_pkg::HMAC_BLOCK)) begin
					rd_idx_q <= rd_idx_q + 7'd1;
				end
			end else if (state_q == totp_pkg::FSM_SHA_WAIT && sha_done) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (comp_acc) begin
			utime_q  <= in_ch.unix_time;
			status_q <= err_status;
		end
		if (state_q == totp_pkg::FSM_DIV1 && div_done) begin
			counter_q <= div_quo;
		end
		rd_use_s1 <= 7'(key_count_q) > rd_idx_q;
		if (rd_v_s1) begin
			key_blk_q <= {key_blk_q[503:0], rd_use_s1 ? rd_data_q : 8'd0};
		end
		if (state_q == totp_pkg::FSM_SHA_WAIT && sha_done) begin
			if (phase_q == 2'd1) begin
				inner_q <= sha_hout;
			end else begin
				h_q <= sha_hout;
			end
		end
		if (out_load) begin
			otp_q   <= (status_q == totp_pkg::ST_OK) ? div_rem : 32'd0;
			ostat_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.otp_value = otp_q;
	assign out_ch.status    = ostat_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_busy)
		else $error("input taken while divider busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CW'(KEY_BYTES))
		else $error("key count beyond store depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (ostat_q != totp_pkg::ST_OK) |-> otp_q == 32'd0)
		else $error("error result with nonzero code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(otp_q))
		else $error("pending result overwritten");

endmodule

### rtl/core/totp_div.sv
module totp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/core/totp_sha1.sv
module totp_sha1 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] blk,
	input  logic [159:0] h_in,
	output logic         done,
	output logic [159:0] h_out
);

	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q;
	logic [6:0]   rnd_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  f;
	logic [31:0]  t;
	logic [31:0]  w_new;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
		end else begin
			f = b_q ^ c_q ^ d_q;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + totp_pkg::sha1_k(rnd_q) + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511 - 32*i -: 32];
			end
			h_q <= h_in;
			a_q <= h_in[159:128];
			b_q <= h_in[127:96];
			c_q <= h_in[95:64];
			d_q <= h_in[63:32];
			e_q <= h_in[31:0];
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign done  = done_q;
	assign h_out = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
		h_q[63:32] + d_q, h_q[31:0] + e_q};

endmodule

### tb/sv/totp_code_generator_test.sv
module totp_code_generator_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [31:0] unix_time;
	} code_req_t;

	typedef struct packed {
		logic [31:0] otp_value;
		logic [1:0]  status;
	} code_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	totp_in_if  in_ch ();
	totp_out_if out_ch ();

	totp_code_generator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	logic [7:0]  key_mem [totp_pkg::KEY_BYTES_DEF];
	int          key_len;
	logic        key_over;
	logic        key_restart;
	logic [7:0]  step_reg;
	logic [31:0] mod_reg;

	code_req_t pending_reqs[$];
	code_rsp_t expected_codes[$];

	int  errors;
	int  phase_items;
	int  phase_codes;
	int  send_gap;
	int  recv_stall;
	int  idle_cycles;
	bit  in_taken;
	bit  out_taken;
	bit  send_burst;
	bit  recv_burst;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [159:0] sha1_compress(logic [159:0] hin, logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++) begin
			w[i] = blk[511 - 32 * i -: 32];
		end
		for (int i = 16; i < 80; i++) begin
			x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
			w[i] = {x[30:0], x[31]};
		end
		{a, b, c, d, e} = hin;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c, hin[63:32] + d,
			hin[31:0] + e};
	endfunction

	// hash of the padded key block xor pad, then one tail block
	function automatic logic [159:0] keyed_digest(logic [7:0] pad, logic [511:0] tail);
		logic [511:0] kblk;
		for (int i = 0; i < 64; i++) begin
			kblk[511 - 8 * i -: 8] = ((i < key_len) ? key_mem[i] : 8'h00) ^ pad;
		end
		return sha1_compress(sha1_compress(totp_pkg::SHA1_IV, kblk), tail);
	endfunction

	function automatic code_rsp_t compute_code(logic [31:0] utime);
		code_rsp_t   r;
		logic [31:0] counter;
		logic [159:0] inner, dig, shifted;
		logic [31:0] trunc;
		r.otp_value = '0;
		if (step_reg == 8'd0) begin
			r.status = totp_pkg::ST_ZERO_STEP;
		end else if (mod_reg == 32'd0) begin
			r.status = totp_pkg::ST_ZERO_MOD;
		end else if (key_over) begin
			r.status = totp_pkg::ST_KEY_LONG;
		end else begin
			counter = utime / {24'd0, step_reg};
			inner = keyed_digest(totp_pkg::IPAD, {32'd0, counter, 8'h80, 408'd0, 32'd576});
			dig = keyed_digest(totp_pkg::OPAD, {inner, 8'h80, 312'd0, 32'd672});
			shifted = dig << (8 * dig[3:0]);
			trunc = shifted[159:128];
			trunc[31] = 1'b0;
			r.otp_value = trunc % mod_reg;
			r.status = totp_pkg::ST_OK;
		end
		return r;
	endfunction

	task automatic apply_request(code_req_t rq);
		if (rq.opcode == totp_pkg::OP_LOAD) begin
			if (key_restart) begin
				key_len = 0;
				key_over = 1'b0;
			end
			if (key_len < totp_pkg::KEY_BYTES_DEF) begin
				key_mem[key_len] = rq.key_byte;
				key_len++;
			end else begin
				key_over = 1'b1;
			end
			key_restart = rq.key_last;
		end else begin
			expected_codes.push_back(compute_code(rq.unix_time));
		end
	endtask

	// monitor and checker
	always @(posedge clk) begin
		code_rsp_t exp_r;
		in_taken <= in_ch.valid && in_ch.ready;
		out_taken <= out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_codes.size() == 0) begin
					$display("%t: unexpected result otp=%0d status=%0d", $realtime,
						out_ch.otp_value, out_ch.status);
					errors++;
				end else begin
					exp_r = expected_codes.pop_front();
					if (exp_r.otp_value !== out_ch.otp_value) begin
						$display("%t: otp_value mismatch expected %0d actual %0d", $realtime,
							exp_r.otp_value, out_ch.otp_value);
						errors++;
					end
					if (exp_r.status !== out_ch.status) begin
						$display("%t: status mismatch expected %0d actual %0d", $realtime,
							exp_r.status, out_ch.status);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				apply_request({in_ch.opcode, in_ch.key_byte, in_ch.key_last, in_ch.unix_time});
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= 5000) begin
				$display("timeout waiting for a transaction");
				$display("** totp_code_generator: FAILED **");
				$finish;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		code_req_t rq;
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if ($urandom_range(0, 39) == 0) begin
				send_burst = !send_burst;
			end
			if (send_gap > 0) begin
				in_ch.valid <= 1'b0;
				send_gap--;
			end else if (pending_reqs.size() > 0) begin
				rq = pending_reqs.pop_front();
				in_ch.opcode <= rq.opcode;
				in_ch.key_byte <= rq.key_byte;
				in_ch.key_last <= rq.key_last;
				in_ch.unix_time <= rq.unix_time;
				in_ch.valid <= 1'b1;
				send_gap = send_burst ? 0 : $urandom_range(0, 5);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 19) == 0) begin
					recv_burst = !recv_burst;
				end
				recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
			end
			if (recv_stall > 0) begin
				out_ch.ready <= 1'b0;
				recv_stall--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_load(logic [7:0] b, logic last);
		code_req_t rq;
		rq.opcode = totp_pkg::OP_LOAD;
		rq.key_byte = b;
		rq.key_last = last;
		rq.unix_time = $urandom;
		pending_reqs.push_back(rq);
		phase_items++;
	endtask

	task automatic add_compute(logic [31:0] t);
		code_req_t rq;
		rq.opcode = totp_pkg::OP_COMPUTE;
		rq.key_byte = $urandom;
		rq.key_last = $urandom;
		rq.unix_time = t;
		pending_reqs.push_back(rq);
		phase_items++;
		phase_codes++;
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || in_ch.valid || expected_codes.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == totp_pkg::REG_TIME_STEP) begin
			step_reg = val[7:0];
		end else begin
			mod_reg = val;
		end
	endtask

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return {24'd0, step_reg} - 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int min_items, int min_codes);
		int len;
		int kind;
		int cut;
		phase_items = 0;
		phase_codes = 0;
		while (phase_items < min_items || phase_codes < min_codes) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				case ($urandom_range(0, 9))
					0, 1: len = $urandom_range(21, 64);
					2: len = $urandom_range(65, 70);
					default: len = $urandom_range(1, 20);
				endcase
				for (int i = 0; i < len; i++) begin
					add_load($urandom, i == len - 1);
				end
				repeat ($urandom_range(1, 2)) add_compute(pick_time());
			end else if (kind < 85) begin
				// compute in the middle of a key load
				len = $urandom_range(2, 12);
				cut = $urandom_range(1, len - 1);
				for (int i = 0; i < len; i++) begin
					if (i == cut) begin
						add_compute(pick_time());
					end
					add_load($urandom, i == len - 1);
				end
				add_compute(pick_time());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) == 0) begin
						add_compute($urandom);
					end else begin
						add_load($urandom, $urandom);
					end
				end
			end
		end
	endtask

	logic [7:0]  steps [10] = '{8'd30, 8'd30, 8'd1, 8'd255, 8'd0, 8'd7, 8'd60, 8'd2, 8'd0, 8'd13};
	logic [31:0] mods [10] = '{32'd1000000, 32'd100000000, 32'hFFFFFFFF, 32'd1, 32'd1000000,
		32'd0, 32'd10, 32'h7FFFFFFF, 32'd0, 32'd999983};

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_gap = 0;
		recv_stall = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = totp_pkg::OP_LOAD;
		in_ch.key_byte = '0;
		in_ch.key_last = 1'b0;
		in_ch.unix_time = '0;
		out_ch.ready = 1'b0;
		key_len = 0;
		key_over = 1'b0;
		key_restart = 1'b1;
		step_reg = totp_pkg::TIME_STEP_RST;
		mod_reg = totp_pkg::CODE_MOD_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty key at extreme times, then the 20-byte ASCII key "1234567890..." at times 59 and 1111111109
		phase_items = 0;
		add_compute(32'd0);
		add_compute(32'hFFFFFFFF);
		for (int i = 0; i < 20; i++) begin
			add_load(8'h30 + 8'((i + 1) % 10), i == 19);
		end
		add_compute(32'd59);
		add_compute(32'd1111111109);
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			write_reg(totp_pkg::REG_TIME_STEP, {24'd0, steps[p]});
			write_reg(totp_pkg::REG_CODE_MOD, mods[p]);
			random_phase(35, 4);
			wait_idle();
		end

		if (errors == 0 && expected_codes.size() == 0) begin
			$display("** totp_code_generator: PASSED **");
		end else begin
			$display("** totp_code_generator: FAILED **");
		end
		$finish;
	end

endmodule
